>>> rtl/core/principal_values_2x2_tensor_assert.svh
// assertion macros for the principal values block
`ifndef PRINCIPAL_VALUES_2X2_TENSOR_ASSERT_SVH
`define PRINCIPAL_VALUES_2X2_TENSOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PV2T_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PV2T_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/core/pv2t_pkg.sv
// shared types and constants of the principal values block
`timescale 1ns / 1ps
`default_nettype none

package pv2t_pkg;

    localparam int DIR_W     = 16;
    localparam int DIR_FRAC  = 14;
    localparam logic signed [DIR_W-1:0] DIR_ONE  = 16'sd16384;
    localparam logic signed [DIR_W-1:0] DIR_ZERO = 16'sd0;

    localparam int NORM_BITS = 30;
    localparam int NSQ_RW    = NORM_BITS + 1;
    localparam int QUO_W     = DIR_W - 1;
    localparam int DIVD_W    = NORM_BITS + DIR_FRAC + 1;

    typedef struct packed {
        logic valid;
        logic zero;
        logic hneg;
        logic sneg;
    } pv2t_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/pv2t_sq_cell.sv
// one step of the shift-add squaring chain, both magnitudes at once
`timescale 1ns / 1ps
`default_nettype none

module pv2t_sq_cell #(
    parameter int MW = 33,
    parameter int AW = 66,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  pv2t_pkg::pv2t_ctl_t ctl_in,
    input  logic [MW-1:0]       hm_in,
    input  logic [MW-1:0]       sm_in,
    input  logic [AW-1:0]       hc_in,
    input  logic [AW-1:0]       sc_in,
    input  logic [AW-1:0]       acc_in,
    input  logic [SW-1:0]       side_in,
    output pv2t_pkg::pv2t_ctl_t ctl_out,
    output logic [MW-1:0]       hm_out,
    output logic [MW-1:0]       sm_out,
    output logic [AW-1:0]       hc_out,
    output logic [AW-1:0]       sc_out,
    output logic [AW-1:0]       acc_out,
    output logic [SW-1:0]       side_out
);

    pv2t_pkg::pv2t_ctl_t ctl_reg;
    logic [MW-1:0] hm_reg, sm_reg, hm_next, sm_next;
    logic [AW-1:0] hc_reg, sc_reg, acc_reg, hc_next, sc_next, acc_next;
    logic [SW-1:0] side_reg;

    assign acc_next = acc_in + (hm_in[0] ? hc_in : '0) + (sm_in[0] ? sc_in : '0);
    assign hm_next  = hm_in >> 1;
    assign sm_next  = sm_in >> 1;
    assign hc_next  = hc_in << 1;
    assign sc_next  = sc_in << 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hm_reg   <= hm_next;
            sm_reg   <= sm_next;
            hc_reg   <= hc_next;
            sc_reg   <= sc_next;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign hm_out   = hm_reg;
    assign sm_out   = sm_reg;
    assign hc_out   = hc_reg;
    assign sc_out   = sc_reg;
    assign acc_out  = acc_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/pv2t_sqrt_cell.sv
// one root bit of a restoring integer square root chain
`timescale 1ns / 1ps
`default_nettype none

module pv2t_sqrt_cell #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  pv2t_pkg::pv2t_ctl_t ctl_in,
    input  logic [2*RW-1:0]     rad_in,
    input  logic [RW:0]         rem_in,
    input  logic [RW-1:0]       root_in,
    input  logic [SW-1:0]       side_in,
    output pv2t_pkg::pv2t_ctl_t ctl_out,
    output logic [2*RW-1:0]     rad_out,
    output logic [RW:0]         rem_out,
    output logic [RW-1:0]       root_out,
    output logic [SW-1:0]       side_out
);

    pv2t_pkg::pv2t_ctl_t ctl_reg;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [SW-1:0]   side_reg;
    logic [RW+2:0]   rem_ext, trial, diff;
    logic            ge;

    // bring down two radicand bits, try root*4+1
    assign rem_ext   = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial     = {1'b0, root_in, 2'b01};
    assign ge        = (rem_ext >= trial);
    assign diff      = rem_ext - trial;
    assign rem_next  = ge ? diff[RW:0] : rem_ext[RW:0];
    assign root_next = {root_in[RW-2:0], ge};
    assign rad_next  = {rad_in[2*RW-3:0], 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/pv2t_norm_cell.sv
// one stage of the leading-one normalizing shifter
`timescale 1ns / 1ps
`default_nettype none

module pv2t_norm_cell #(
    parameter int NL = 34,
    parameter int SH = 1,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  pv2t_pkg::pv2t_ctl_t ctl_in,
    input  logic [NL-1:0]       p_in,
    input  logic [NL-1:0]       q_in,
    input  logic [SW-1:0]       side_in,
    output pv2t_pkg::pv2t_ctl_t ctl_out,
    output logic [NL-1:0]       p_out,
    output logic [NL-1:0]       q_out,
    output logic [SW-1:0]       side_out
);

    pv2t_pkg::pv2t_ctl_t ctl_reg;
    logic [NL-1:0] p_reg, q_reg, p_next, q_next;
    logic [SW-1:0] side_reg;
    logic          top_clear;

    // shift both when the top SH bits of both are all clear
    assign top_clear = ~|(p_in[NL-1 -: SH] | q_in[NL-1 -: SH]);
    assign p_next    = top_clear ? (p_in << SH) : p_in;
    assign q_next    = top_clear ? (q_in << SH) : q_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign p_out    = p_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/pv2t_div_cell.sv
// one quotient bit of two restoring divisions by a shared divisor
`timescale 1ns / 1ps
`default_nettype none

module pv2t_div_cell #(
    parameter int SW = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  pv2t_pkg::pv2t_ctl_t              ctl_in,
    input  logic [pv2t_pkg::NSQ_RW-1:0]      n_in,
    input  logic [pv2t_pkg::NSQ_RW-1:0]      ra_in,
    input  logic [pv2t_pkg::NSQ_RW-1:0]      rb_in,
    input  logic [pv2t_pkg::QUO_W-1:0]       da_in,
    input  logic [pv2t_pkg::QUO_W-1:0]       db_in,
    input  logic [pv2t_pkg::QUO_W-1:0]       qa_in,
    input  logic [pv2t_pkg::QUO_W-1:0]       qb_in,
    input  logic [SW-1:0]                    side_in,
    output pv2t_pkg::pv2t_ctl_t              ctl_out,
    output logic [pv2t_pkg::NSQ_RW-1:0]      n_out,
    output logic [pv2t_pkg::NSQ_RW-1:0]      ra_out,
    output logic [pv2t_pkg::NSQ_RW-1:0]      rb_out,
    output logic [pv2t_pkg::QUO_W-1:0]       da_out,
    output logic [pv2t_pkg::QUO_W-1:0]       db_out,
    output logic [pv2t_pkg::QUO_W-1:0]       qa_out,
    output logic [pv2t_pkg::QUO_W-1:0]       qb_out,
    output logic [SW-1:0]                    side_out
);

    localparam int NR = pv2t_pkg::NSQ_RW;
    localparam int QW = pv2t_pkg::QUO_W;

    pv2t_pkg::pv2t_ctl_t ctl_reg;
    logic [NR-1:0] n_reg, ra_reg, rb_reg, ra_next, rb_next;
    logic [QW-1:0] da_reg, db_reg, qa_reg, qb_reg, da_next, db_next, qa_next, qb_next;
    logic [SW-1:0] side_reg;
    logic [NR:0]   n_ext, ta, tb, sa, sb;
    logic          ge_a, ge_b;

    assign n_ext   = {1'b0, n_in};
    assign ta      = {ra_in, da_in[QW-1]};
    assign tb      = {rb_in, db_in[QW-1]};
    assign ge_a    = (ta >= n_ext);
    assign ge_b    = (tb >= n_ext);
    assign sa      = ta - n_ext;
    assign sb      = tb - n_ext;
    assign ra_next = ge_a ? sa[NR-1:0] : ta[NR-1:0];
    assign rb_next = ge_b ? sb[NR-1:0] : tb[NR-1:0];
    assign qa_next = {qa_in[QW-2:0], ge_a};
    assign qb_next = {qb_in[QW-2:0], ge_b};
    assign da_next = {da_in[QW-2:0], 1'b0};
    assign db_next = {db_in[QW-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_in;
            ra_reg   <= ra_next;
            rb_reg   <= rb_next;
            da_reg   <= da_next;
            db_reg   <= db_next;
            qa_reg   <= qa_next;
            qb_reg   <= qb_next;
            side_reg <= side_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign n_out    = n_reg;
    assign ra_out   = ra_reg;
    assign rb_out   = rb_reg;
    assign da_out   = da_reg;
    assign db_out   = db_reg;
    assign qa_out   = qa_reg;
    assign qb_out   = qb_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/principal_values_2x2_tensor.sv
// top level: principal values and unit directions of a symmetric 2x2 tensor
// usage:
//   item channel (item_valid/item_ready) takes one tensor word per cycle when ready:
//   normal_xx, normal_yy, shear_xy and is_strain (shear halved in strain mode)
//   result channel (result_valid/result_ready) gives both principal values,
//   saturated, and their Q1.14 unit directions, one word per item, in order
//   throughput is one word per cycle while the receiver takes results; the
//   stages are an input register, a shift-add squaring chain, a bit-per-cell
//   square root for the radius, a value register, a log shifter, a 30x30
//   squaring stage, a sum register, a 31-cell root for the norm, a dividend
//   register, a 15-cell divider pair for the direction components and the
//   output register
//   the whole chain advances while the output register is empty or taken,
//   so a stalled receiver freezes every cell and drops item_ready
//   at reset all valid flags clear; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module principal_values_2x2_tensor #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic signed [VALUE_WIDTH-1:0] normal_xx,
    input  logic signed [VALUE_WIDTH-1:0] normal_yy,
    input  logic signed [VALUE_WIDTH-1:0] shear_xy,
    input  logic                          is_strain,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [VALUE_WIDTH-1:0] major_value,
    output logic signed [VALUE_WIDTH-1:0] minor_value,
    output logic signed [15:0]            major_dir_x,
    output logic signed [15:0]            major_dir_y,
    output logic signed [15:0]            minor_dir_x,
    output logic signed [15:0]            minor_dir_y
);

    localparam int W     = VALUE_WIDTH;
    localparam int HW    = W + 1;                 // magnitude width of h and s
    localparam int AW    = 2 * HW;                // h*h + s*s
    localparam int NL    = (W + 2 > pv2t_pkg::NORM_BITS) ? W + 2 : pv2t_pkg::NORM_BITS;
    localparam int NK    = $clog2(NL);
    localparam int NB    = pv2t_pkg::NORM_BITS;
    localparam int NR    = pv2t_pkg::NSQ_RW;
    localparam int QW    = pv2t_pkg::QUO_W;
    localparam int DVW   = pv2t_pkg::DIVD_W;
    localparam int DRW   = pv2t_pkg::DIR_W;
    localparam int SIDE1 = 2 * W + 2 * HW;        // xx, yy, |h|, |s|
    localparam int SIDE2 = 2 * W;                 // major, minor
    localparam int SIDE3 = 2 * W + 2 * NB;        // values, normalized p and q

    logic adv;

    // the chain moves whenever the output register can take a word
    assign adv        = !result_valid || result_ready;
    assign item_ready = adv;

    // ------------------------------------------------------------------
    // input stage: doubled shear, difference and magnitudes
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t s0_ctl_reg, s0_ctl_next;
    logic [W-1:0]  s0_xx_reg, s0_yy_reg;
    logic [HW-1:0] s0_habs_reg, s0_sabs_reg, s0_habs_next, s0_sabs_next;
    logic [HW-1:0] in_s, in_h;

    always_comb
    begin
        // work on doubled values so that strain halving stays exact
        in_s = is_strain ? {shear_xy[W-1], shear_xy} : {shear_xy, 1'b0};
        in_h = {normal_xx[W-1], normal_xx} - {normal_yy[W-1], normal_yy};
        s0_habs_next = in_h[HW-1] ? (~in_h + 1'b1) : in_h;
        s0_sabs_next = in_s[HW-1] ? (~in_s + 1'b1) : in_s;
        s0_ctl_next.valid = item_valid;
        s0_ctl_next.zero  = (in_s == '0);
        s0_ctl_next.hneg  = in_h[HW-1];
        s0_ctl_next.sneg  = in_s[HW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_xx_reg   <= normal_xx;
            s0_yy_reg   <= normal_yy;
            s0_habs_reg <= s0_habs_next;
            s0_sabs_reg <= s0_sabs_next;
        end
    end

    // ------------------------------------------------------------------
    // squaring chain: acc = h*h + s*s, one multiplier bit per cell
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t sq_ctl [0:HW];
    logic [HW-1:0]    sq_hm   [0:HW];
    logic [HW-1:0]    sq_sm   [0:HW];
    logic [AW-1:0]    sq_hc   [0:HW];
    logic [AW-1:0]    sq_sc   [0:HW];
    logic [AW-1:0]    sq_acc  [0:HW];
    logic [SIDE1-1:0] sq_side [0:HW];

    assign sq_ctl[0]  = s0_ctl_reg;
    assign sq_hm[0]   = s0_habs_reg;
    assign sq_sm[0]   = s0_sabs_reg;
    assign sq_hc[0]   = AW'(s0_habs_reg);
    assign sq_sc[0]   = AW'(s0_sabs_reg);
    assign sq_acc[0]  = '0;
    assign sq_side[0] = {s0_xx_reg, s0_yy_reg, s0_habs_reg, s0_sabs_reg};

    for (genvar i = 0; i < HW; i++)
    begin : g_sq
        pv2t_sq_cell #(.MW(HW), .AW(AW), .SW(SIDE1)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (sq_ctl[i]),
            .hm_in    (sq_hm[i]),
            .sm_in    (sq_sm[i]),
            .hc_in    (sq_hc[i]),
            .sc_in    (sq_sc[i]),
            .acc_in   (sq_acc[i]),
            .side_in  (sq_side[i]),
            .ctl_out  (sq_ctl[i+1]),
            .hm_out   (sq_hm[i+1]),
            .sm_out   (sq_sm[i+1]),
            .hc_out   (sq_hc[i+1]),
            .sc_out   (sq_sc[i+1]),
            .acc_out  (sq_acc[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // radius chain: r = floor(sqrt(h*h + s*s))
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t r_ctl [0:HW];
    logic [AW-1:0]    r_rad  [0:HW];
    logic [HW:0]      r_rem  [0:HW];
    logic [HW-1:0]    r_root [0:HW];
    logic [SIDE1-1:0] r_side [0:HW];

    assign r_ctl[0]  = sq_ctl[HW];
    assign r_rad[0]  = sq_acc[HW];
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_side[0] = sq_side[HW];

    for (genvar i = 0; i < HW; i++)
    begin : g_rad
        pv2t_sqrt_cell #(.RW(HW), .SW(SIDE1)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (r_ctl[i]),
            .rad_in   (r_rad[i]),
            .rem_in   (r_rem[i]),
            .root_in  (r_root[i]),
            .side_in  (r_side[i]),
            .ctl_out  (r_ctl[i+1]),
            .rad_out  (r_rad[i+1]),
            .rem_out  (r_rem[i+1]),
            .root_out (r_root[i+1]),
            .side_out (r_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // value stage: floor((xx + yy +- r) / 2), saturated, or xx and yy with no shear; a = |h| + r
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] sat_half(input logic [W+2:0] t);
        logic [W+1:0] v;
        logic [W-1:0] res;
        begin
            v = t[W+2:1];
            if ((&v[W+1:W-1]) || !(|v[W+1:W-1]))
            begin
                res = v[W-1:0];
            end
            else
            begin
                res = v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            return res;
        end
    endfunction

    pv2t_pkg::pv2t_ctl_t va_ctl_reg;
    logic [NL-1:0]    va_p_reg, va_q_reg, va_p_next, va_q_next;
    logic [W-1:0]     va_maj_reg, va_min_reg, va_maj_next, va_min_next;
    logic [W-1:0]     va_xx, va_yy;
    logic [HW-1:0]    va_habs, va_sabs, va_r;
    logic [W+2:0]     va_tot_p, va_tot_m;
    logic [W+1:0]     va_a;

    always_comb
    begin
        va_xx    = r_side[HW][SIDE1-1 -: W];
        va_yy    = r_side[HW][SIDE1-1-W -: W];
        va_habs  = r_side[HW][2*HW-1 -: HW];
        va_sabs  = r_side[HW][HW-1:0];
        va_r     = r_root[HW];
        va_tot_p = {{3{va_xx[W-1]}}, va_xx} + {{3{va_yy[W-1]}}, va_yy} + {2'b00, va_r};
        va_tot_m = {{3{va_xx[W-1]}}, va_xx} + {{3{va_yy[W-1]}}, va_yy} - {2'b00, va_r};
        va_a     = {1'b0, va_habs} + {1'b0, va_r};
        va_p_next = NL'(va_a);
        va_q_next = NL'(va_sabs);
        if (r_ctl[HW].zero)
        begin
            // no shear: the axes are already principal
            va_maj_next = va_xx;
            va_min_next = va_yy;
        end
        else
        begin
            va_maj_next = sat_half(va_tot_p);
            va_min_next = sat_half(va_tot_m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_ctl_reg <= '0;
        end
        else if (adv)
        begin
            va_ctl_reg <= r_ctl[HW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            va_p_reg   <= va_p_next;
            va_q_reg   <= va_q_next;
            va_maj_reg <= va_maj_next;
            va_min_reg <= va_min_next;
        end
    end

    // ------------------------------------------------------------------
    // normalizing shifter: leading one of max(a, |s|) to the top
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t nm_ctl [0:NK];
    logic [NL-1:0]    nm_p    [0:NK];
    logic [NL-1:0]    nm_q    [0:NK];
    logic [SIDE2-1:0] nm_side [0:NK];

    assign nm_ctl[0]  = va_ctl_reg;
    assign nm_p[0]    = va_p_reg;
    assign nm_q[0]    = va_q_reg;
    assign nm_side[0] = {va_maj_reg, va_min_reg};

    for (genvar i = 0; i < NK; i++)
    begin : g_norm
        pv2t_norm_cell #(.NL(NL), .SH(1 << (NK - 1 - i)), .SW(SIDE2)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (nm_ctl[i]),
            .p_in     (nm_p[i]),
            .q_in     (nm_q[i]),
            .side_in  (nm_side[i]),
            .ctl_out  (nm_ctl[i+1]),
            .p_out    (nm_p[i+1]),
            .q_out    (nm_q[i+1]),
            .side_out (nm_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // square stage and sum stage of the norm radicand
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t mq_ctl_reg, ns_ctl_reg;
    logic [NB-1:0]    mq_p_reg, mq_q_reg, ns_p_reg, ns_q_reg, mq_p, mq_q;
    logic [2*NB-1:0]  mq_psq_reg, mq_qsq_reg;
    logic [2*NR-1:0]  ns_sum_reg, ns_sum_next;
    logic [SIDE2-1:0] mq_val_reg, ns_val_reg;

    // top NORM_BITS of the normalized word put max(p, q) in [2^29, 2^30)
    assign mq_p        = nm_p[NK][NL-1 -: NB];
    assign mq_q        = nm_q[NK][NL-1 -: NB];
    assign ns_sum_next = (2*NR)'(mq_psq_reg) + (2*NR)'(mq_qsq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mq_ctl_reg <= '0;
            ns_ctl_reg <= '0;
        end
        else if (adv)
        begin
            mq_ctl_reg <= nm_ctl[NK];
            ns_ctl_reg <= mq_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mq_p_reg   <= mq_p;
            mq_q_reg   <= mq_q;
            mq_psq_reg <= (2*NB)'(mq_p) * (2*NB)'(mq_p);
            mq_qsq_reg <= (2*NB)'(mq_q) * (2*NB)'(mq_q);
            mq_val_reg <= nm_side[NK];
            ns_p_reg   <= mq_p_reg;
            ns_q_reg   <= mq_q_reg;
            ns_sum_reg <= ns_sum_next;
            ns_val_reg <= mq_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // norm chain: n = floor(sqrt(p*p + q*q))
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t n_ctl [0:NR];
    logic [2*NR-1:0]  n_rad  [0:NR];
    logic [NR:0]      n_rem  [0:NR];
    logic [NR-1:0]    n_root [0:NR];
    logic [SIDE3-1:0] n_side [0:NR];

    assign n_ctl[0]  = ns_ctl_reg;
    assign n_rad[0]  = ns_sum_reg;
    assign n_rem[0]  = '0;
    assign n_root[0] = '0;
    assign n_side[0] = {ns_val_reg, ns_p_reg, ns_q_reg};

    for (genvar i = 0; i < NR; i++)
    begin : g_nrm
        pv2t_sqrt_cell #(.RW(NR), .SW(SIDE3)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (n_ctl[i]),
            .rad_in   (n_rad[i]),
            .rem_in   (n_rem[i]),
            .root_in  (n_root[i]),
            .side_in  (n_side[i]),
            .ctl_out  (n_ctl[i+1]),
            .rad_out  (n_rad[i+1]),
            .rem_out  (n_rem[i+1]),
            .root_out (n_root[i+1]),
            .side_out (n_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // dividend stage: c * 2^14 + n/2, rounding half away from zero
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t dd_ctl_reg;
    logic [NR-1:0]    dd_n_reg, dd_ra_reg, dd_rb_reg;
    logic [QW-1:0]    dd_da_reg, dd_db_reg;
    logic [SIDE2-1:0] dd_val_reg;
    logic [DVW-1:0]   dd_a_next, dd_b_next, dd_half;
    logic [NB-1:0]    dd_p, dd_q;

    always_comb
    begin
        dd_p      = n_side[NR][2*NB-1 -: NB];
        dd_q      = n_side[NR][NB-1:0];
        dd_half   = DVW'(n_root[NR] >> 1);
        dd_a_next = {1'b0, dd_p, {pv2t_pkg::DIR_FRAC{1'b0}}} + dd_half;
        dd_b_next = {1'b0, dd_q, {pv2t_pkg::DIR_FRAC{1'b0}}} + dd_half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_ctl_reg <= '0;
        end
        else if (adv)
        begin
            dd_ctl_reg <= n_ctl[NR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_n_reg   <= n_root[NR];
            dd_ra_reg  <= {1'b0, dd_a_next[DVW-1:QW]};
            dd_rb_reg  <= {1'b0, dd_b_next[DVW-1:QW]};
            dd_da_reg  <= dd_a_next[QW-1:0];
            dd_db_reg  <= dd_b_next[QW-1:0];
            dd_val_reg <= n_side[NR][SIDE3-1 -: SIDE2];
        end
    end

    // ------------------------------------------------------------------
    // divider chain: both components over the shared norm
    // ------------------------------------------------------------------
    pv2t_pkg::pv2t_ctl_t dv_ctl [0:QW];
    logic [NR-1:0]    dv_n    [0:QW];
    logic [NR-1:0]    dv_ra   [0:QW];
    logic [NR-1:0]    dv_rb   [0:QW];
    logic [QW-1:0]    dv_da   [0:QW];
    logic [QW-1:0]    dv_db   [0:QW];
    logic [QW-1:0]    dv_qa   [0:QW];
    logic [QW-1:0]    dv_qb   [0:QW];
    logic [SIDE2-1:0] dv_side [0:QW];

    assign dv_ctl[0]  = dd_ctl_reg;
    assign dv_n[0]    = dd_n_reg;
    assign dv_ra[0]   = dd_ra_reg;
    assign dv_rb[0]   = dd_rb_reg;
    assign dv_da[0]   = dd_da_reg;
    assign dv_db[0]   = dd_db_reg;
    assign dv_qa[0]   = '0;
    assign dv_qb[0]   = '0;
    assign dv_side[0] = dd_val_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        pv2t_div_cell #(.SW(SIDE2)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (dv_ctl[i]),
            .n_in     (dv_n[i]),
            .ra_in    (dv_ra[i]),
            .rb_in    (dv_rb[i]),
            .da_in    (dv_da[i]),
            .db_in    (dv_db[i]),
            .qa_in    (dv_qa[i]),
            .qb_in    (dv_qb[i]),
            .side_in  (dv_side[i]),
            .ctl_out  (dv_ctl[i+1]),
            .n_out    (dv_n[i+1]),
            .ra_out   (dv_ra[i+1]),
            .rb_out   (dv_rb[i+1]),
            .da_out   (dv_da[i+1]),
            .db_out   (dv_db[i+1]),
            .qa_out   (dv_qa[i+1]),
            .qb_out   (dv_qb[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output register: pick direction pairs and signs
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    logic [W-1:0]          maj_reg, min_reg;
    logic [DRW-1:0]        mjx_reg, mjy_reg, mnx_reg, mny_reg;
    logic [DRW-1:0]        mjx_next, mjy_next, mnx_next, mny_next;
    logic [DRW-1:0]        xa, xb, xa_neg, xb_neg;
    pv2t_pkg::pv2t_ctl_t   oc;

    always_comb
    begin
        oc     = dv_ctl[QW];
        xa     = {1'b0, dv_qa[QW]};        // component along a = |h| + r
        xb     = {1'b0, dv_qb[QW]};        // component along |s|
        xa_neg = ~xa + 1'b1;
        xb_neg = ~xb + 1'b1;
        if (oc.zero)
        begin
            mjx_next = pv2t_pkg::DIR_ONE;
            mjy_next = pv2t_pkg::DIR_ZERO;
            mnx_next = pv2t_pkg::DIR_ZERO;
            mny_next = pv2t_pkg::DIR_ONE;
        end
        else if (!oc.hneg)
        begin
            // major along (a, s), minor along (|s|, -sign(s) a)
            mjx_next = xa;
            mjy_next = oc.sneg ? xb_neg : xb;
            mnx_next = xb;
            mny_next = oc.sneg ? xa : xa_neg;
        end
        else
        begin
            // major along (|s|, sign(s) a), minor along (a, -s)
            mjx_next = xb;
            mjy_next = oc.sneg ? xa_neg : xa;
            mnx_next = xa;
            mny_next = oc.sneg ? xb : xb_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= oc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            maj_reg <= dv_side[QW][SIDE2-1 -: W];
            min_reg <= dv_side[QW][W-1:0];
            mjx_reg <= mjx_next;
            mjy_reg <= mjy_next;
            mnx_reg <= mnx_next;
            mny_reg <= mny_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign major_value  = maj_reg;
    assign minor_value  = min_reg;
    assign major_dir_x  = mjx_reg;
    assign major_dir_y  = mjy_reg;
    assign minor_dir_x  = mnx_reg;
    assign minor_dir_y  = mny_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic dir_x_ok;

    // x components of both directions stay within [0, 1.0]
    assign dir_x_ok = (major_dir_x >= pv2t_pkg::DIR_ZERO) && (major_dir_x <= pv2t_pkg::DIR_ONE)
                   && (minor_dir_x >= pv2t_pkg::DIR_ZERO) && (minor_dir_x <= pv2t_pkg::DIR_ONE);

`include "principal_values_2x2_tensor_assert.svh"

    `PV2T_ASSERT_IMP(a_empty_ready, !result_valid, item_ready, "chain stalled with empty output")
    `PV2T_ASSERT_NXT(a_last_cell_out, dv_ctl[QW].valid && adv, result_valid, "word lost")
    `PV2T_ASSERT_IMP(a_dir_x_range, result_valid, dir_x_ok, "direction x out of range")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// testbench for the principal values and directions of a symmetric 2x2 tensor
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int VW = 32;
    // pipeline depth at the default width, plus margin for the final flush
    localparam int FLUSH_CYCLES = 160;
    // generous cycle budget: every word waiting out the longest gaps and stalls
    localparam int CYCLE_LIMIT = 400000;

    // one result word as the block should deliver it
    typedef struct {
        logic signed [VW-1:0] major;
        logic signed [VW-1:0] minor;
        logic signed [15:0]   maj_x;
        logic signed [15:0]   maj_y;
        logic signed [15:0]   min_x;
        logic signed [15:0]   min_y;
    } principal_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic signed [VW-1:0] normal_xx = '0;
    logic signed [VW-1:0] normal_yy = '0;
    logic signed [VW-1:0] shear_xy = '0;
    logic                 is_strain = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic signed [VW-1:0] major_value;
    logic signed [VW-1:0] minor_value;
    logic signed [15:0]   major_dir_x;
    logic signed [15:0]   major_dir_y;
    logic signed [15:0]   minor_dir_x;
    logic signed [15:0]   minor_dir_y;

    principal_t pending_results[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    // when set, neither side inserts gaps or stalls
    bit         full_rate = 1'b0;

    principal_values_2x2_tensor #(.VALUE_WIDTH(VW)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .normal_xx    (normal_xx),
        .normal_yy    (normal_yy),
        .shear_xy     (shear_xy),
        .is_strain    (is_strain),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .major_value  (major_value),
        .minor_value  (minor_value),
        .major_dir_x  (major_dir_x),
        .major_dir_y  (major_dir_y),
        .minor_dir_x  (minor_dir_x),
        .minor_dir_y  (minor_dir_y)
    );

    always #4 clk = ~clk;

    // floor square root of a value below 2^114, one result bit per step
    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [127:0] acc;
        logic [127:0] trial;
        acc = '0;
        for (int b = 56; b >= 0; b--)
        begin
            trial = acc | (128'd1 << b);
            if (trial * trial <= v)
                acc = trial;
        end
        return acc[63:0];
    endfunction

    // scale (p, q) so the larger lies in [2^29, 2^30), then divide by the norm
    // with ties rounded away from zero
    task automatic unit_vector(input logic [63:0] p, input logic [63:0] q,
                               input bit q_neg,
                               output logic signed [15:0] ux,
                               output logic signed [15:0] uy);
        logic [63:0] big;
        logic [63:0] norm;
        logic [63:0] cx;
        logic [63:0] cy;
        int          top;
        big = (p > q) ? p : q;
        top = 63;
        while (top > 0 && !big[top])
            top--;
        if (top > 29)
        begin
            p = p >> (top - 29);
            q = q >> (top - 29);
        end
        else
        begin
            p = p << (29 - top);
            q = q << (29 - top);
        end
        norm = floor_root({64'd0, p * p + q * q});
        if (norm == 0)
            norm = 1;
        cx = ((p << 14) + norm / 2) / norm;
        cy = ((q << 14) + norm / 2) / norm;
        ux = cx[15:0];
        uy = q_neg ? -cy[15:0] : cy[15:0];
    endtask

    function automatic logic signed [VW-1:0] clamp_value(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[VW-1:0];
    endfunction

    // principal values and directions of one tensor word, computed on doubled
    // values so the strain halving is exact
    task automatic predict_principal(input logic signed [VW-1:0] xx,
                                     input logic signed [VW-1:0] yy,
                                     input logic signed [VW-1:0] sh,
                                     input logic strain,
                                     output principal_t res);
        longint      sx;
        longint      dh;
        logic [63:0] h_mag;
        logic [63:0] s_mag;
        logic [63:0] radius;
        logic [63:0] along;
        logic [127:0] sum_sq;
        bit          s_neg;
        sx = strain ? longint'(sh) : 2 * longint'(sh);
        if (sx == 0)
        begin
            // no shear: the axes are already principal
            res.major = xx;
            res.minor = yy;
            res.maj_x = 16'sd16384;
            res.maj_y = 16'sd0;
            res.min_x = 16'sd0;
            res.min_y = 16'sd16384;
            return;
        end
        dh = longint'(xx) - longint'(yy);
        h_mag = (dh < 0) ? -dh : dh;
        s_mag = (sx < 0) ? -sx : sx;
        s_neg = sx < 0;
        sum_sq = {64'd0, h_mag} * {64'd0, h_mag} + {64'd0, s_mag} * {64'd0, s_mag};
        radius = floor_root(sum_sq);
        // arithmetic shift gives the floor of the half for negatives too
        res.major = clamp_value((longint'(xx) + longint'(yy) + longint'(radius)) >>> 1);
        res.minor = clamp_value((longint'(xx) + longint'(yy) - longint'(radius)) >>> 1);
        along = h_mag + radius;
        if (dh >= 0)
        begin
            unit_vector(along, s_mag, s_neg, res.maj_x, res.maj_y);
            unit_vector(s_mag, along, !s_neg, res.min_x, res.min_y);
        end
        else
        begin
            unit_vector(s_mag, along, s_neg, res.maj_x, res.maj_y);
            unit_vector(along, s_mag, !s_neg, res.min_x, res.min_y);
        end
    endtask

    // drive one tensor word and record its prediction once it is accepted
    task automatic send_word(input logic signed [VW-1:0] xx,
                             input logic signed [VW-1:0] yy,
                             input logic signed [VW-1:0] sh,
                             input logic strain);
        int         gap;
        principal_t res;
        gap = full_rate ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        normal_xx  <= xx;
        normal_yy  <= yy;
        shear_xy   <= sh;
        is_strain  <= strain;
        predict_principal(xx, yy, sh, strain, res);
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(res);
    endtask

    task automatic release_input();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full-range field, a value within a million of zero, or a small magnitude near zero to hit exact cases
    function automatic logic signed [VW-1:0] draw_value();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 64)) - 32;
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    // corners of the fields, both modes, tiny and extreme shear
    task automatic test_extremes();
        logic signed [VW-1:0] vmax;
        logic signed [VW-1:0] vmin;
        vmax = 32'sh7fffffff;
        vmin = 32'sh80000000;
        send_word(vmax, vmax, vmax, 1'b0);
        send_word(vmin, vmin, vmin, 1'b0);
        send_word(vmax, vmin, vmin, 1'b0);
        send_word(vmin, vmax, vmax, 1'b1);
        send_word(vmax, vmax, vmin, 1'b1);
        send_word(vmin, vmin, vmax, 1'b0);
        send_word(0, 0, 0, 1'b0);
        send_word(-1, -1, -1, 1'b1);
        send_word(0, 0, 1, 1'b1);
        send_word(0, 0, -1, 1'b1);
        send_word(vmax, 0, 1, 1'b0);
        send_word(vmin, vmax, 0, 1'b1);
        release_input();
    endtask

    // zero shear, equal normals, and a negative normal difference
    task automatic test_special();
        send_word(32'sh00030000, 32'sh00010000, 0, 1'b0);
        send_word(-32'sh00050000, 32'sh00020000, 0, 1'b1);
        send_word(32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0);
        send_word(32'sh00010000, 32'sh00010000, -32'sh00010000, 1'b1);
        send_word(-32'sh00020000, 32'sh00040000, 32'sh00008000, 1'b0);
        send_word(-32'sh00020000, 32'sh00040000, -32'sh00008000, 1'b1);
        send_word(32'sh00040000, -32'sh00020000, -32'sh00008000, 1'b0);
        send_word(12345, 12345, 2, 1'b1);
        release_input();
    endtask

    // random words, with a burst at full rate on both sides
    task automatic test_random(input int count);
        logic signed [VW-1:0] xx;
        logic signed [VW-1:0] yy;
        logic signed [VW-1:0] sh;
        for (int i = 0; i < count; i++)
        begin
            full_rate = (i >= count / 2) && (i < count / 2 + 200);
            xx = draw_value();
            yy = ($urandom_range(0, 7) == 0) ? xx : draw_value();
            sh = ($urandom_range(0, 9) == 0) ? '0 : draw_value();
            send_word(xx, yy, sh, 1'($urandom_range(0, 1)));
        end
        full_rate = 1'b0;
        release_input();
    endtask

    // sender holds off until the pipeline has drained, then restarts
    task automatic test_drain_restart();
        test_random(30);
        wait (pending_results.size() == 0);
        @(posedge clk);
        test_random(30);
    endtask

    // result side: compare each word, then draw the stall before the next
    always @(posedge clk)
    begin
        principal_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word major %0d", $time, major_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (major_value !== want.major)
                    begin
                        $display("%0t: major_value exp %0d got %0d", $time, want.major,
                                 major_value);
                        fail_count++;
                    end
                    if (minor_value !== want.minor)
                    begin
                        $display("%0t: minor_value exp %0d got %0d", $time, want.minor,
                                 minor_value);
                        fail_count++;
                    end
                    if (major_dir_x !== want.maj_x)
                    begin
                        $display("%0t: major_dir_x exp %0d got %0d", $time, want.maj_x,
                                 major_dir_x);
                        fail_count++;
                    end
                    if (major_dir_y !== want.maj_y)
                    begin
                        $display("%0t: major_dir_y exp %0d got %0d", $time, want.maj_y,
                                 major_dir_y);
                        fail_count++;
                    end
                    if (minor_dir_x !== want.min_x)
                    begin
                        $display("%0t: minor_dir_x exp %0d got %0d", $time, want.min_x,
                                 minor_dir_x);
                        fail_count++;
                    end
                    if (minor_dir_y !== want.min_y)
                    begin
                        $display("%0t: minor_dir_y exp %0d got %0d", $time, want.min_y,
                                 minor_dir_y);
                        fail_count++;
                    end
                end
                stall_left = full_rate ? 0 : $urandom_range(0, 3);
                result_ready <= (stall_left == 0);
            end
            else if (!result_ready)
            begin
                // count down the stall, then take the next word
                if (stall_left <= 1)
                    result_ready <= 1'b1;
                stall_left = stall_left - 1;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        result_ready <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special();
        test_drain_restart();
        test_random(1270);
        wait (pending_results.size() == 0);
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
